/* src/stn_pkg.sv */
package stn_pkg;

    localparam int W_BITS         = 23;
    localparam int DIV_BITS       = 24;
    localparam int X_BITS         = 16;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = DIV_BITS / BITS_PER_STAGE;
    localparam int ROOT_BITS      = 12;

    localparam logic [X_BITS-1:0]    SEED_ESTIMATE = 16'h00FF;
    localparam logic [6:0]           SCALE_FACTOR  = 7'd100;
    localparam logic [ROOT_BITS-1:0] RESULT_MAX    = 12'hFFF;
    localparam logic [X_BITS-1:0]    QUOT_ZERO_DIV = 16'hFFFF;

    // one in-flight word of the root pipeline
    typedef struct packed {
        logic                zero;
        logic [W_BITS-1:0]   w;
        logic [X_BITS-1:0]   x;
        logic [X_BITS-1:0]   rem;
        logic [DIV_BITS-1:0] dsh;
        logic [X_BITS-1:0]   q;
    } data_t;

    // restoring division, BITS_PER_STAGE quotient bits; q keeps the low 16 bits
    function automatic data_t div_step(data_t d);
        data_t       r;
        logic [16:0] t;
        r = d;
        for (int k = 0; k < BITS_PER_STAGE; k++)
        begin
            t     = {r.rem, r.dsh[DIV_BITS-1]};
            r.dsh = {r.dsh[DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, r.x})
            begin
                t   = t - {1'b0, r.x};
                r.q = {r.q[X_BITS-2:0], 1'b1};
            end
            else
            begin
                r.q = {r.q[X_BITS-2:0], 1'b0};
            end
            r.rem = t[X_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [X_BITS-1:0] next_x(data_t d);
        logic [X_BITS-1:0] qf;
        logic [X_BITS:0]   s;
        qf = (d.x == '0) ? QUOT_ZERO_DIV : d.q;
        s  = {1'b0, d.x} + {1'b0, qf};
        return s[X_BITS:1];
    endfunction

endpackage

/* src/stn_step.sv */
// one Newton step: DIV_STAGES division stages, average folded into the last
module stn_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  stn_pkg::data_t in_data,
    output logic          out_vld,
    output stn_pkg::data_t out_data
);
    import stn_pkg::*;

    data_t                  stage_in [DIV_STAGES];
    data_t                  data_next [DIV_STAGES];
    data_t                  data_reg [DIV_STAGES];
    logic  [DIV_STAGES-1:0] vld_reg;

    always_comb
    begin
        stage_in[0]     = in_data;
        stage_in[0].rem = '0;
        stage_in[0].dsh = {{(DIV_BITS-W_BITS){1'b0}}, in_data.w};
        stage_in[0].q   = '0;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            stage_in[i] = data_reg[i-1];
        end
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            data_next[i] = div_step(stage_in[i]);
        end
        data_next[DIV_STAGES-1].x = next_x(div_step(stage_in[DIV_STAGES-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                data_reg[i] <= data_next[i];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_data = data_reg[DIV_STAGES-1];

endmodule

/* src/sqrt_times_ten_newton_unit.sv */
// Path from accepted word to out_valid: entry register, STEP_COUNT Newton steps, output register.
// Throughput: one word per cycle; the whole pipe advances whenever the output
// register is empty or being taken, so a stall freezes every stage in place.
// Each Newton step is a 4-bit-per-stage restoring divider (6 stages).
// Reset: rst_n asynchronous, active low; clears all stage valid bits only.
module sqrt_times_ten_newton_unit #(
    parameter int STEP_COUNT = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [15:0]                  value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [stn_pkg::ROOT_BITS-1:0] root_times_ten
);
    import stn_pkg::*;

    // global advance: whole pipe moves together
    logic en;

    // entry stage: scale by 100, load seed
    logic  in_vld_reg;
    data_t in_data_reg;
    data_t in_data_next;

    logic  step_vld  [STEP_COUNT+1];
    data_t step_data [STEP_COUNT+1];

    // output register
    logic                 out_vld_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS-1:0] root_next;

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        in_data_next      = '0;
        in_data_next.zero = (value == '0);
        in_data_next.w    = W_BITS'({7'd0, value} * {16'd0, SCALE_FACTOR});
        in_data_next.x    = SEED_ESTIMATE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg  <= in_valid;
            out_vld_reg <= step_vld[STEP_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_data_reg <= in_data_next;
            root_reg    <= root_next;
        end
    end

    assign step_vld[0]  = in_vld_reg;
    assign step_data[0] = in_data_reg;

    // a repeated estimate stays fixed, so all steps run with no early exit
    for (genvar s = 0; s < STEP_COUNT; s++)
    begin : g_step
        stn_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (step_vld[s]),
            .in_data  (step_data[s]),
            .out_vld  (step_vld[s+1]),
            .out_data (step_data[s+1])
        );
    end

    // zero operand forces zero; saturate large estimates
    always_comb
    begin
        if (step_data[STEP_COUNT].zero)
        begin
            root_next = '0;
        end
        else if (step_data[STEP_COUNT].x > {{(X_BITS-ROOT_BITS){1'b0}}, RESULT_MAX})
        begin
            root_next = RESULT_MAX;
        end
        else
        begin
            root_next = step_data[STEP_COUNT].x[ROOT_BITS-1:0];
        end
    end

    assign out_valid      = out_vld_reg;
    assign root_times_ten = root_reg;

endmodule

/* src/stn_checker.sv */
module stn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] root_times_ten
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output drains");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root_times_ten))
        else $error("stalled result changed");

endmodule

bind sqrt_times_ten_newton_unit stn_checker u_stn_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .root_times_ten (root_times_ten)
);

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stn_pkg::*;

    // Slack waited at the end so the block's pipeline can drain.
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1800;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [15:0]          value;
    logic                 out_valid;
    logic                 out_ready;
    logic [ROOT_BITS-1:0] root_times_ten;

    sqrt_times_ten_newton_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .root_times_ten (root_times_ten)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Operands waiting to be sent, and roots waiting to come back.
    logic [15:0]          operand_q[$];
    logic [ROOT_BITS-1:0] root_q[$];
    int                   error_count = 0;
    int                   cycle_count = 0;
    bit                   idle_off    = 1'b0;
    bit                   hold_send   = 1'b0;

    // Integer Newton root of value*100 from seed 255, up to six steps,
    // stopping once an estimate repeats; clipped to 12 bits.
    function automatic logic [ROOT_BITS-1:0] root_x10(logic [15:0] v);
        logic [31:0] w;
        logic [31:0] x;
        logic [31:0] prev;
        logic [31:0] q;
        w    = 32'(v) * 32'd100;
        x    = 32'(SEED_ESTIMATE);
        prev = '0;
        if (v == '0)
            return '0;
        for (int s = 0; s < 6; s++)
        begin
            // a zero divisor gives all ones, as the hardware guards it
            q = (x != 0) ? ((w / x) & 32'hFFFF) : 32'hFFFF;
            x = ((x + q) >> 1) & 32'hFFFF;
            if (x == prev)
                break;
            prev = x;
        end
        if (x > 32'(RESULT_MAX))
            x = 32'(RESULT_MAX);
        return x[ROOT_BITS-1:0];
    endfunction

    // Sender: random idle bursts unless idling is off.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                root_q.push_back(root_x10(value));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (operand_q.size() > 0 && !hold_send)
                begin
                    in_valid <= 1'b1;
                    value    <= operand_q.pop_front();
                    if (!idle_off && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 18);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, compare each root with the oldest expectation.
    int take_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (root_q.size() == 0)
                begin
                    $error("root_times_ten: unexpected word, actual %0d", root_times_ten);
                    error_count++;
                end
                else
                begin
                    logic [ROOT_BITS-1:0] want;
                    want = root_q.pop_front();
                    if (want !== root_times_ten)
                    begin
                        $error("root_times_ten: expected %0d, actual %0d",
                               want, root_times_ten);
                        error_count++;
                    end
                end
            end
            if (take_gap > 0)
            begin
                take_gap  <= take_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!idle_off && $urandom_range(0, 11) == 0)
            begin
                take_gap  <= $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] r;
        rst_n = 1'b0;
        // Directed: zero, one, extremes, perfect squares, single bits.
        operand_q.push_back(16'd0);
        operand_q.push_back(16'd1);
        operand_q.push_back(16'd2);
        operand_q.push_back(16'd3);
        operand_q.push_back(16'd4);
        operand_q.push_back(16'd99);
        operand_q.push_back(16'd100);
        operand_q.push_back(16'd650);
        operand_q.push_back(16'd651);
        operand_q.push_back(16'd65025);
        operand_q.push_back(16'hFFFE);
        operand_q.push_back(16'hFFFF);
        operand_q.push_back(16'h5555);
        operand_q.push_back(16'hAAAA);
        for (int b = 0; b < 16; b += 3)
            operand_q.push_back(16'(1) << b);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Hold the sender until every directed root is back.
        wait (operand_q.size() == 0);
        hold_send = 1'b1;
        wait (!in_valid && root_q.size() == 0);

        // Random: half full range, a quarter small operands, a quarter near the top.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            case ($urandom_range(0, 3))
                0:       r = 16'($urandom_range(0, 255));
                1:       r = 16'($urandom_range(65000, 65535));
                default: r = 16'($urandom);
            endcase
            operand_q.push_back(r);
        end
        hold_send = 1'b0;

        // Last stretch runs with no idling on either side.
        wait (operand_q.size() < 300);
        idle_off = 1'b1;
        wait (operand_q.size() == 0);
        wait (!in_valid && root_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && root_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
